[hdl/touch_button_hit_test_core_defines.svh]
// Assertion macros for the touch button hit test core.
// Included by the top level; no other dependencies.
`ifndef TOUCH_BUTTON_HIT_TEST_CORE_DEFINES_SVH
`define TOUCH_BUTTON_HIT_TEST_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// Antecedent true: consequent holds in the same cycle.
`define TBHT_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Antecedent true: consequent holds in the next cycle.
`define TBHT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define TBHT_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define TBHT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

[hdl/tbht_pkg.sv]
// Shared types and constants for the touch button hit test core.
// No dependencies; used by the controller, datapath and top level.
package tbht_pkg;

    localparam int RAW_W      = 10;
    localparam int CNT_W      = 4;
    localparam int COORD_W    = 12;
    localparam int NUM_W      = 20;
    localparam int GEO_W      = 14;
    localparam int DIV_CNT_W  = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 32;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_COLUMNS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CAL_X_MIN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CAL_X_MAX = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CAL_Y_MIN = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CAL_Y_MAX = 3'd6;

    // Reset values
    localparam logic [2:0]       RST_COLUMNS   = 3'd4;
    localparam logic [3:0]       RST_ROWS      = 4'd1;
    localparam logic [7:0]       RST_HEIGHT    = 8'd20;
    localparam logic [RAW_W-1:0] RST_CAL_X_MIN = 10'd125;
    localparam logic [RAW_W-1:0] RST_CAL_X_MAX = 10'd907;
    localparam logic [RAW_W-1:0] RST_CAL_Y_MIN = 10'd130;
    localparam logic [RAW_W-1:0] RST_CAL_Y_MAX = 10'd935;

    // Button grid geometry
    localparam int BTN_ORIGIN      = 4;
    localparam int BTN_GAP         = 5;
    localparam int BTN_TRIM        = 3;
    localparam int WIDTH_TRIM      = 6;
    localparam int WIDTH_TRIM_2COL = 9;
    localparam logic [7:0] MIN_HEIGHT = 8'd20;
    localparam logic [2:0] MAX_COLUMNS = 3'd4;

    // Saturation limits
    localparam logic [NUM_W-1:0]          SAT_MAG_NEG = 20'd2048;
    localparam logic [NUM_W-1:0]          SAT_MAG_POS = 20'd2047;
    localparam logic signed [COORD_W-1:0] SAT_HI      = 12'sh7FF;
    localparam logic signed [COORD_W-1:0] SAT_LO      = 12'sh800;

    typedef struct packed {
        logic load;
        logic mul;
        logic div_step;
        logic sat;
        logic scan_step;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic scan_done;
        logic out_free;
    } t_stat;

endpackage

[hdl/tbht_ctrl.sv]
// Sequencer for the touch button hit test core.
// Depends on tbht_pkg for the command and status structs.
module tbht_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    input  tbht_pkg::t_stat  i_stat,
    output tbht_pkg::t_cmd   o_cmd
);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_MUL  = 6'b000010,
        ST_DIV  = 6'b000100,
        ST_SAT  = 6'b001000,
        ST_SCAN = 6'b010000,
        ST_DONE = 6'b100000
    } t_state;

    localparam logic [tbht_pkg::DIV_CNT_W-1:0] DIV_LAST =
        tbht_pkg::DIV_CNT_W'(tbht_pkg::NUM_W - 1);

    t_state                           r_state, n_state;
    logic [tbht_pkg::DIV_CNT_W-1:0]   r_div_cnt, n_div_cnt;

    always_comb begin
        n_state   = r_state;
        n_div_cnt = r_div_cnt;
        o_cmd     = '0;
        o_s_tready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_MUL;
                end
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_div_cnt = '0;
                n_state   = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                n_div_cnt      = r_div_cnt + 1'b1;
                if (r_div_cnt == DIV_LAST) begin
                    n_state = ST_SAT;
                end
            end
            ST_SAT: begin
                o_cmd.sat = 1'b1;
                n_state   = ST_SCAN;
            end
            ST_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_stat.scan_done) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_div_cnt <= '0;
        end else begin
            r_state   <= n_state;
            r_div_cnt <= n_div_cnt;
        end
    end

endmodule

[hdl/tbht_datapath.sv]
// Datapath of the touch button hit test core: registers, scaling, divider,
// grid walk and output register. Depends on tbht_pkg.
module tbht_datapath #(
    parameter int SCREEN_WIDTH  = 320,
    parameter int SCREEN_HEIGHT = 240,
    parameter int MAX_BUTTONS   = 12
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [tbht_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [tbht_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic [tbht_pkg::S_TDATA_W-1:0]      i_s_tdata,
    input  logic                                i_m_tready,
    output logic                                o_m_tvalid,
    output logic [tbht_pkg::M_TDATA_W-1:0]      o_m_tdata,
    input  tbht_pkg::t_cmd                      i_cmd,
    output tbht_pkg::t_stat                     o_stat
);

    localparam int RW = tbht_pkg::RAW_W;
    localparam int NW = tbht_pkg::NUM_W;
    localparam int CW = tbht_pkg::COORD_W;
    localparam int GW = tbht_pkg::GEO_W;
    localparam int KW = tbht_pkg::CNT_W;

    localparam int W4 = SCREEN_WIDTH / 4 - tbht_pkg::WIDTH_TRIM;
    localparam int W3 = SCREEN_WIDTH / 3 - tbht_pkg::WIDTH_TRIM;
    localparam int W2 = SCREEN_WIDTH / 2 - tbht_pkg::WIDTH_TRIM_2COL;
    localparam int W1 = SCREEN_WIDTH - tbht_pkg::WIDTH_TRIM;
    localparam logic [KW:0] CAP4 = (KW+1)'(MAX_BUTTONS / 4);
    localparam logic [KW:0] CAP3 = (KW+1)'(MAX_BUTTONS / 3);
    localparam logic [KW:0] CAP2 = (KW+1)'(MAX_BUTTONS / 2);
    localparam logic [KW:0] CAP1 = (KW+1)'(MAX_BUTTONS);
    localparam logic [RW-1:0] SW_U = RW'(SCREEN_WIDTH);
    localparam logic [RW-1:0] SH_U = RW'(SCREEN_HEIGHT);
    localparam logic signed [GW-1:0] ORIGIN = GW'(tbht_pkg::BTN_ORIGIN);
    localparam logic signed [GW-1:0] GAP    = GW'(tbht_pkg::BTN_GAP);
    localparam logic signed [GW-1:0] TRIM   = GW'(tbht_pkg::BTN_TRIM);
    localparam logic signed [GW-1:0] SH_S   = GW'(SCREEN_HEIGHT);

    // One restoring-division step: returns {remainder, shifted quotient}.
    function automatic logic [RW+NW-1:0] div_step(
        input logic [NW-1:0] num,
        input logic [RW-1:0] rem,
        input logic [RW-1:0] den
    );
        logic [RW:0] t;
        logic [RW:0] d;
        t = {rem, num[NW-1]};
        d = {1'b0, den};
        if (t >= d) begin
            div_step = {RW'(t - d), num[NW-2:0], 1'b1};
        end else begin
            div_step = {t[RW-1:0], num[NW-2:0], 1'b0};
        end
    endfunction

    function automatic logic signed [CW-1:0] saturate(
        input logic [NW-1:0] q,
        input logic          neg,
        input logic          ok
    );
        logic signed [CW-1:0] v;
        if (!ok) begin
            v = '0;
        end else if (neg) begin
            if (q >= tbht_pkg::SAT_MAG_NEG) begin
                v = tbht_pkg::SAT_LO;
            end else begin
                v = -$signed({1'b0, q[CW-2:0]});
            end
        end else begin
            if (q > tbht_pkg::SAT_MAG_POS) begin
                v = tbht_pkg::SAT_HI;
            end else begin
                v = $signed({1'b0, q[CW-2:0]});
            end
        end
        saturate = v;
    endfunction

    // Configuration registers
    logic [2:0]    r_columns;
    logic [3:0]    r_rows;
    logic [7:0]    r_height;
    logic [RW-1:0] r_cal_x_min, r_cal_x_max, r_cal_y_min, r_cal_y_max;

    // Item registers
    logic [RW-1:0] r_raw_x, r_raw_y;
    logic [KW-1:0] r_cnt;
    logic          r_ok_x, r_ok_y, r_neg_x, r_neg_y;
    logic [NW-1:0] r_num_x, r_num_y;
    logic [RW-1:0] r_rem_x, r_rem_y, r_den_x, r_den_y;
    logic signed [CW-1:0] r_px, r_py;

    // Grid walk
    logic [KW-1:0] r_idx, r_hit;
    logic [2:0]    r_col;
    logic [KW:0]   r_row;
    logic signed [GW-1:0] r_bx, r_by;

    // Output register
    logic          r_m_valid;
    logic [KW-1:0] r_m_hit;
    logic signed [CW-1:0] r_m_px, r_m_py;

    logic signed [RW:0]   diff_x, diff_y, mag_x, mag_y;
    logic [NW-1:0]        prod_x, prod_y;
    logic [RW+NW-1:0]     step_x, step_y;
    logic [2:0]           c_eff;
    logic signed [GW-1:0] w, h_s, px_s, py_s, bx_right, by_bottom, y0;
    logic [7:0]           h_eff;
    logic [KW:0]          cap, r_eff, limit;
    logic                 ok, at_end, btn_valid, in_box, hit_now, last_col;

    always_comb begin
        diff_x = $signed({1'b0, r_raw_x}) - $signed({1'b0, r_cal_x_min});
        diff_y = $signed({1'b0, r_raw_y}) - $signed({1'b0, r_cal_y_min});
        mag_x  = diff_x[RW] ? -diff_x : diff_x;
        mag_y  = diff_y[RW] ? -diff_y : diff_y;
        prod_x = NW'(mag_x[RW-1:0]) * NW'(SW_U);
        prod_y = NW'(mag_y[RW-1:0]) * NW'(SH_U);
        step_x = div_step(r_num_x, r_rem_x, r_den_x);
        step_y = div_step(r_num_y, r_rem_y, r_den_y);

        if (r_columns == 3'd0) begin
            c_eff = 3'd1;
        end else if (r_columns > tbht_pkg::MAX_COLUMNS) begin
            c_eff = tbht_pkg::MAX_COLUMNS;
        end else begin
            c_eff = r_columns;
        end
        case (c_eff)
            3'd4: begin
                w   = GW'(W4);
                cap = CAP4;
            end
            3'd3: begin
                w   = GW'(W3);
                cap = CAP3;
            end
            3'd2: begin
                w   = GW'(W2);
                cap = CAP2;
            end
            default: begin
                w   = GW'(W1);
                cap = CAP1;
            end
        endcase
        h_eff = (r_height < tbht_pkg::MIN_HEIGHT) ? tbht_pkg::MIN_HEIGHT : r_height;
        h_s   = $signed({{(GW-8){1'b0}}, h_eff});
        r_eff = ({1'b0, r_rows} > cap) ? cap : {1'b0, r_rows};
        limit = ({1'b0, r_cnt} > CAP1) ? CAP1 : {1'b0, r_cnt};
        y0    = SH_S - h_s - ORIGIN;

        px_s      = $signed({{(GW-CW){r_px[CW-1]}}, r_px});
        py_s      = $signed({{(GW-CW){r_py[CW-1]}}, r_py});
        bx_right  = r_bx + w - TRIM;
        by_bottom = r_by + h_s - TRIM;
        in_box    = (px_s >= r_bx) && (px_s <= bx_right) &&
                    (py_s >= r_by) && (py_s <= by_bottom);
        ok        = r_ok_x && r_ok_y;
        at_end    = ({1'b0, r_idx} == limit);
        btn_valid = (r_row < r_eff);
        hit_now   = ok && !at_end && btn_valid && in_box;
        last_col  = (r_col == 3'(c_eff - 3'd1));

        o_stat.scan_done = !ok || at_end || hit_now;
        o_stat.out_free  = !r_m_valid || i_m_tready;
    end

    // Configuration and output valid: control state, reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_columns   <= tbht_pkg::RST_COLUMNS;
            r_rows      <= tbht_pkg::RST_ROWS;
            r_height    <= tbht_pkg::RST_HEIGHT;
            r_cal_x_min <= tbht_pkg::RST_CAL_X_MIN;
            r_cal_x_max <= tbht_pkg::RST_CAL_X_MAX;
            r_cal_y_min <= tbht_pkg::RST_CAL_Y_MIN;
            r_cal_y_max <= tbht_pkg::RST_CAL_Y_MAX;
            r_m_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    tbht_pkg::REG_COLUMNS:   r_columns   <= i_cfg_data[2:0];
                    tbht_pkg::REG_ROWS:      r_rows      <= i_cfg_data[3:0];
                    tbht_pkg::REG_HEIGHT:    r_height    <= i_cfg_data[7:0];
                    tbht_pkg::REG_CAL_X_MIN: r_cal_x_min <= i_cfg_data;
                    tbht_pkg::REG_CAL_X_MAX: r_cal_x_max <= i_cfg_data;
                    tbht_pkg::REG_CAL_Y_MIN: r_cal_y_min <= i_cfg_data;
                    tbht_pkg::REG_CAL_Y_MAX: r_cal_y_max <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.out_load) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_raw_x <= i_s_tdata[RW-1:0];
            r_raw_y <= i_s_tdata[2*RW-1:RW];
            r_cnt   <= i_s_tdata[2*RW+KW-1:2*RW];
        end
        if (i_cmd.mul) begin
            r_ok_x  <= (r_cal_x_max > r_cal_x_min);
            r_ok_y  <= (r_cal_y_max > r_cal_y_min);
            r_neg_x <= diff_x[RW];
            r_neg_y <= diff_y[RW];
            r_num_x <= prod_x;
            r_num_y <= prod_y;
            r_rem_x <= '0;
            r_rem_y <= '0;
            r_den_x <= r_cal_x_max - r_cal_x_min;
            r_den_y <= r_cal_y_max - r_cal_y_min;
        end
        if (i_cmd.div_step) begin
            {r_rem_x, r_num_x} <= step_x;
            {r_rem_y, r_num_y} <= step_y;
        end
        if (i_cmd.sat) begin
            r_px  <= saturate(r_num_x, r_neg_x, r_ok_x);
            r_py  <= saturate(r_num_y, r_neg_y, r_ok_y);
            r_idx <= '0;
            r_col <= '0;
            r_row <= '0;
            r_bx  <= ORIGIN;
            r_by  <= y0;
            r_hit <= r_cnt;
        end
        if (i_cmd.scan_step) begin
            if (hit_now) begin
                r_hit <= r_idx;
            end else if (!o_stat.scan_done) begin
                // Advance to the next button of the grid
                r_idx <= r_idx + 1'b1;
                if (last_col) begin
                    r_col <= '0;
                    r_row <= r_row + 1'b1;
                    r_bx  <= ORIGIN;
                    r_by  <= r_by - h_s - GAP;
                end else begin
                    r_col <= r_col + 1'b1;
                    r_bx  <= r_bx + w + GAP;
                end
            end
        end
        if (i_cmd.out_load) begin
            r_m_hit <= r_hit;
            r_m_px  <= r_px;
            r_m_py  <= r_py;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {{(tbht_pkg::M_TDATA_W - KW - 2*CW){1'b0}},
                         r_m_py, r_m_px, r_m_hit};

endmodule

[hdl/touch_button_hit_test_core.sv]
// Top level of the touch button hit test core; depends on tbht_pkg, tbht_ctrl, tbht_datapath.
// Flow: a new item is taken only in idle, once the last result is in the output register;
// the scan ends at the first hit, after min(count, MAX_BUTTONS) buttons on a miss, or at
// once on bad calibration; a held result adds stalls. Accept to result valid: multiply, 20
// divide steps (one quotient bit per cycle, both axes in parallel), saturate, scan, hand-off.
// Reset: synchronous, active low; loads the default calibration and grid registers.
`include "touch_button_hit_test_core_defines.svh"

module touch_button_hit_test_core #(
    parameter int SCREEN_WIDTH  = 320,
    parameter int SCREEN_HEIGHT = 240,
    parameter int MAX_BUTTONS   = 12
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Configuration write port
    input  logic                              i_cfg_we,
    input  logic [tbht_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [tbht_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // Input beat
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // [9:0] raw_x, [19:10] raw_y, [23:20] buttons_to_check
    input  logic [tbht_pkg::S_TDATA_W-1:0]    i_s_tdata,
    // Result beat
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // [3:0] hit_index, [15:4] mapped_x, [27:16] mapped_y, [31:28] zero
    output logic [tbht_pkg::M_TDATA_W-1:0]    o_m_tdata
);

    tbht_pkg::t_cmd  cmd;
    tbht_pkg::t_stat stat;

    // Sequencer: idle -> multiply -> divide -> saturate -> grid scan -> hand off.
    tbht_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // Datapath: holds calibration, scales both axes, walks the button grid
    // and keeps the result in an output register so the next beat can be
    // taken while the result waits.
    tbht_datapath #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT),
        .MAX_BUTTONS   (MAX_BUTTONS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tdata   (i_s_tdata),
        .i_m_tready  (i_m_tready),
        .o_m_tvalid  (o_m_tvalid),
        .o_m_tdata   (o_m_tdata),
        .i_cmd       (cmd),
        .o_stat      (stat)
    );

    // Once a beat is taken, the block stays busy for the next cycle.
    `TBHT_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_s_tvalid && o_s_tready, !o_s_tready)
    // A result is only loaded into a free output slot.
    `TBHT_ASSERT_SAME(a_load_into_free, i_clk, i_rst_n, cmd.out_load, stat.out_free)
    // Loading the output register raises the result valid.
    `TBHT_ASSERT_NEXT(a_load_shows_valid, i_clk, i_rst_n, cmd.out_load, o_m_tvalid)

endmodule

[tb/sv/touch_button_hit_test_core_tb.sv]
// Self-checking testbench for touch_button_hit_test_core: stream driver, result monitor,
// and an in-bench predictor of screen mapping and first-hit button search.
// Depends on tbht_pkg and the RTL of the core; reads no files.
module touch_button_hit_test_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SCR_W           = 320;
    localparam int SCR_H           = 240;
    localparam int N_BTN           = 12;
    localparam int ITEMS_PER_PHASE = 85;
    localparam int CHOKE_CYCLES    = 400;

    // One touch sample, laid out exactly as the input tdata
    typedef struct packed {
        logic [tbht_pkg::CNT_W-1:0] count;
        logic [tbht_pkg::RAW_W-1:0] raw_y;
        logic [tbht_pkg::RAW_W-1:0] raw_x;
    } t_touch_sample;

    // One hit report, laid out exactly as the output tdata
    typedef struct packed {
        logic [3:0]                          pad;
        logic signed [tbht_pkg::COORD_W-1:0] mapped_y;
        logic signed [tbht_pkg::COORD_W-1:0] mapped_x;
        logic [tbht_pkg::CNT_W-1:0]          hit_index;
    } t_hit_report;

    logic                            i_clk       = 1'b0;
    logic                            i_rst_n     = 1'b0;
    logic                            cfg_we      = 1'b0;
    logic [tbht_pkg::CFG_IDX_W-1:0]  cfg_index   = '0;
    logic [tbht_pkg::CFG_DATA_W-1:0] cfg_data    = '0;
    logic                            s_tvalid    = 1'b0;
    logic                            s_tready;
    logic [tbht_pkg::S_TDATA_W-1:0]  s_tdata     = '0;
    logic                            m_tvalid;
    logic                            m_tready    = 1'b0;
    logic [tbht_pkg::M_TDATA_W-1:0]  m_tdata;

    // Register mirror and the button grid built from it
    logic [2:0]                 reg_columns;
    logic [3:0]                 reg_rows;
    logic [7:0]                 reg_height;
    logic [tbht_pkg::RAW_W-1:0] cal_x_min, cal_x_max, cal_y_min, cal_y_max;
    int               btn_x [N_BTN];
    int               btn_y [N_BTN];
    int               btn_w [N_BTN];
    int               btn_h [N_BTN];
    bit               btn_valid [N_BTN];
    int               grid_size;

    // Samples waiting to be sent and reports waiting to come back
    t_touch_sample    touch_queue [$];
    t_hit_report      expected_reports [$];
    t_touch_sample    cur_touch = '0;
    bit               offering  = 1'b0;
    int               send_gap  = 0;
    bit               calm      = 1'b0;

    t_hit_report      pred_report;
    t_hit_report      got_report, want_report;
    int               rcv_stall  = 0;
    int               choke_left = 0;

    int n_fail = 0, n_accepted = 0, n_results = 0, n_hits = 0, n_chokes = 0, n_settings = 0;

    touch_button_hit_test_core #(
        .SCREEN_WIDTH  (SCR_W),
        .SCREEN_HEIGHT (SCR_H),
        .MAX_BUTTONS   (N_BTN)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Rebuild the button grid from the mirrored registers: clamp columns to 1..4,
    // hold height at 20 or more, limit rows to what fits in the store.
    function automatic void build_grid();
        int c, r, w, h, y, n;
        c = reg_columns;
        if (c == 0) c = 1;
        if (c > 4) c = 4;
        case (c)
            4:       w = SCR_W / 4 - tbht_pkg::WIDTH_TRIM;
            3:       w = SCR_W / 3 - tbht_pkg::WIDTH_TRIM;
            2:       w = SCR_W / 2 - tbht_pkg::WIDTH_TRIM_2COL;
            default: w = SCR_W - tbht_pkg::WIDTH_TRIM;
        endcase
        h = reg_height;
        if (h < 20) h = 20;
        r = reg_rows;
        if (r > N_BTN / c) r = N_BTN / c;
        for (int i = 0; i < N_BTN; i++) btn_valid[i] = 1'b0;
        y = SCR_H - h - tbht_pkg::BTN_ORIGIN;
        n = 0;
        for (int j = 0; j < r; j++) begin
            for (int i = 0; i < c && n < N_BTN; i++) begin
                btn_x[n]     = tbht_pkg::BTN_ORIGIN + i * (w + tbht_pkg::BTN_GAP);
                btn_y[n]     = y;
                btn_w[n]     = w;
                btn_h[n]     = h;
                btn_valid[n] = 1'b1;
                n++;
            end
            y -= h + tbht_pkg::BTN_GAP;
        end
        grid_size = n;
    endfunction

    // Scale one raw axis to screen pixels; signed divide truncates toward zero.
    function automatic logic signed [tbht_pkg::COORD_W-1:0] map_axis(int raw, int lo, int hi,
                                                                     int size);
        longint v;
        if (hi <= lo) return '0;
        v = (longint'(raw) - lo) * size / (hi - lo);
        if (v > 2047) v = 2047;
        if (v < -2048) v = -2048;
        return v[tbht_pkg::COORD_W-1:0];
    endfunction

    // Expected report for one sample under the current register mirror
    function automatic t_hit_report predict_touch(t_touch_sample s);
        t_hit_report rep;
        int          px, py, lim;
        bit          found;
        rep.pad       = '0;
        rep.mapped_x  = map_axis(s.raw_x, cal_x_min, cal_x_max, SCR_W);
        rep.mapped_y  = map_axis(s.raw_y, cal_y_min, cal_y_max, SCR_H);
        rep.hit_index = s.count;
        px    = rep.mapped_x;
        py    = rep.mapped_y;
        lim   = (s.count < N_BTN) ? s.count : N_BTN;
        found = 1'b0;
        // A bad calibration on either axis blocks every hit
        if (cal_x_max > cal_x_min && cal_y_max > cal_y_min) begin
            for (int i = 0; i < lim && !found; i++) begin
                if (btn_valid[i] &&
                    px >= btn_x[i] && px <= btn_x[i] + btn_w[i] - tbht_pkg::BTN_TRIM &&
                    py >= btn_y[i] && py <= btn_y[i] + btn_h[i] - tbht_pkg::BTN_TRIM) begin
                    rep.hit_index = tbht_pkg::CNT_W'(i);
                    found = 1'b1;
                end
            end
        end
        return rep;
    endfunction

    // Smallest raw reading that maps at or past a screen target (roughly, for negatives)
    function automatic logic [tbht_pkg::RAW_W-1:0] raw_for(int target, int lo, int hi,
                                                           int size);
        int v;
        if (hi <= lo) return tbht_pkg::RAW_W'($urandom);
        v = lo + (target * (hi - lo) + size - 1) / size;
        if (v < 0) v = 0;
        if (v > 1023) v = 1023;
        return v[tbht_pkg::RAW_W-1:0];
    endfunction

    function automatic t_touch_sample mk_touch(int x, int y, int c);
        t_touch_sample s;
        s = {tbht_pkg::CNT_W'(c), tbht_pkg::RAW_W'(y), tbht_pkg::RAW_W'(x)};
        return s;
    endfunction

    // Pick a coordinate on, just inside or just outside a button edge, or anywhere inside
    function automatic int pick_coord(int lo_edge, int span);
        case ($urandom_range(0, 5))
            0:       return lo_edge;
            1:       return lo_edge + span - tbht_pkg::BTN_TRIM;
            2:       return lo_edge - 1;
            3:       return lo_edge + span - tbht_pkg::BTN_TRIM + 1;
            default: return lo_edge + $urandom_range(0, span - tbht_pkg::BTN_TRIM);
        endcase
    endfunction

    // Mostly aim at a built button; the rest is uniform noise and full-scale readings
    function automatic t_touch_sample random_touch();
        t_touch_sample s;
        int            mode, b, r;
        mode    = $urandom_range(0, 99);
        s.raw_x = tbht_pkg::RAW_W'($urandom);
        s.raw_y = tbht_pkg::RAW_W'($urandom);
        if (mode < 65 && grid_size > 0) begin
            b       = $urandom_range(0, grid_size - 1);
            s.raw_x = raw_for(pick_coord(btn_x[b], btn_w[b]), cal_x_min, cal_x_max, SCR_W);
            s.raw_y = raw_for(pick_coord(btn_y[b], btn_h[b]), cal_y_min, cal_y_max, SCR_H);
        end else if (mode >= 85) begin
            s.raw_x = $urandom_range(0, 1) ? '1 : '0;
            s.raw_y = $urandom_range(0, 1) ? '1 : '0;
        end
        r = $urandom_range(0, 19);
        if (r < 16)      s.count = tbht_pkg::CNT_W'($urandom_range(0, N_BTN));
        else if (r < 18) s.count = tbht_pkg::CNT_W'(N_BTN);
        else             s.count = tbht_pkg::CNT_W'($urandom_range(N_BTN + 1, 15));
        return s;
    endfunction

    // Idle length: mostly none or short, now and then a long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 15);
        return $urandom_range(40, 120);
    endfunction

    // Drive one register write on the next edge and update the mirror to match
    task automatic write_reg(logic [tbht_pkg::CFG_IDX_W-1:0] idx, int val);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= tbht_pkg::CFG_DATA_W'(val);
        case (idx)
            tbht_pkg::REG_COLUMNS:   reg_columns = 3'(val);
            tbht_pkg::REG_ROWS:      reg_rows    = 4'(val);
            tbht_pkg::REG_HEIGHT:    reg_height  = 8'(val);
            tbht_pkg::REG_CAL_X_MIN: cal_x_min   = tbht_pkg::RAW_W'(val);
            tbht_pkg::REG_CAL_X_MAX: cal_x_max   = tbht_pkg::RAW_W'(val);
            tbht_pkg::REG_CAL_Y_MIN: cal_y_min   = tbht_pkg::RAW_W'(val);
            tbht_pkg::REG_CAL_Y_MAX: cal_y_max   = tbht_pkg::RAW_W'(val);
            default: ;
        endcase
        build_grid();
    endtask

    // Hold until every queued sample is sent and every report has come back
    task automatic drain();
        while (touch_queue.size() != 0 || offering || expected_reports.size() != 0)
            @(posedge i_clk);
    endtask

    // Program all seven registers, then send one batch of random touches
    task automatic run_phase(int cols, int rws, int hgt, int xlo, int xhi, int ylo, int yhi,
                             bit quiet);
        calm = quiet;
        write_reg(tbht_pkg::REG_COLUMNS, cols);
        write_reg(tbht_pkg::REG_ROWS, rws);
        write_reg(tbht_pkg::REG_HEIGHT, hgt);
        write_reg(tbht_pkg::REG_CAL_X_MIN, xlo);
        write_reg(tbht_pkg::REG_CAL_X_MAX, xhi);
        write_reg(tbht_pkg::REG_CAL_Y_MIN, ylo);
        write_reg(tbht_pkg::REG_CAL_Y_MAX, yhi);
        @(posedge i_clk);
        cfg_we <= 1'b0;
        n_settings++;
        repeat (ITEMS_PER_PHASE) touch_queue.push_back(random_touch());
        drain();
    endtask

    // Driver: present one beat at a time, predict its report on acceptance, then
    // idle for a random gap before taking the next sample off the queue.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            offering  = 1'b0;
            send_gap  = 0;
            cur_touch = '0;
            s_tvalid <= 1'b0;
        end else begin
            if (offering && s_tready) begin
                pred_report = predict_touch(cur_touch);
                expected_reports.push_back(pred_report);
                if (pred_report.hit_index != cur_touch.count) n_hits++;
                n_accepted++;
                offering = 1'b0;
                send_gap = calm ? 0 : idle_len();
            end
            if (!offering) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (touch_queue.size() != 0) begin
                    cur_touch = touch_queue.pop_front();
                    offering  = 1'b1;
                end
            end
            // Single update per edge keeps back-to-back beats glitch-free
            s_tvalid <= offering;
            s_tdata  <= cur_touch;
        end
    end

    // Monitor: check each result beat against the oldest prediction, stall at random,
    // and twice hold off for a long stretch so the core backs up and drops tready.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rcv_stall  = 0;
            choke_left = 0;
            m_tready  <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got_report = m_tdata;
                if (expected_reports.size() == 0) begin
                    $error("result beat with nothing expected: tdata=%h", m_tdata);
                    n_fail++;
                end else begin
                    want_report = expected_reports.pop_front();
                    if (got_report.hit_index !== want_report.hit_index) begin
                        $error("hit_index: expected %0d, got %0d",
                               want_report.hit_index, got_report.hit_index);
                        n_fail++;
                    end
                    if (got_report.mapped_x !== want_report.mapped_x) begin
                        $error("mapped_x: expected %0d, got %0d",
                               want_report.mapped_x, got_report.mapped_x);
                        n_fail++;
                    end
                    if (got_report.mapped_y !== want_report.mapped_y) begin
                        $error("mapped_y: expected %0d, got %0d",
                               want_report.mapped_y, got_report.mapped_y);
                        n_fail++;
                    end
                    if (got_report.pad !== want_report.pad) begin
                        $error("pad: expected %h, got %h", want_report.pad, got_report.pad);
                        n_fail++;
                    end
                end
                n_results++;
                if (n_results == 150 || n_results == 600) begin
                    choke_left = CHOKE_CYCLES;
                    n_chokes++;
                end
            end
            if (choke_left > 0) begin
                choke_left--;
                m_tready <= 1'b0;
            end else if (rcv_stall > 0) begin
                rcv_stall--;
                m_tready <= 1'b0;
            end else begin
                rcv_stall = (calm || $urandom_range(0, 5) != 0) ? 0 : idle_len();
                m_tready <= (rcv_stall == 0);
            end
        end
    end

    // Main sequence: reset, directed touches on the reset grid, then register sweeps
    initial begin
        reg_columns = tbht_pkg::RST_COLUMNS;
        reg_rows    = tbht_pkg::RST_ROWS;
        reg_height  = tbht_pkg::RST_HEIGHT;
        cal_x_min   = tbht_pkg::RST_CAL_X_MIN;
        cal_x_max   = tbht_pkg::RST_CAL_X_MAX;
        cal_y_min   = tbht_pkg::RST_CAL_Y_MIN;
        cal_y_max   = tbht_pkg::RST_CAL_Y_MAX;
        build_grid();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        n_settings++;

        // Directed: raw extremes, calibration corners, and for each reset button its
        // center (checked and excluded by count), left edge, and just past its right edge
        touch_queue.push_back(mk_touch(0, 0, 0));
        touch_queue.push_back(mk_touch(1023, 1023, 15));
        touch_queue.push_back(mk_touch(0, 1023, N_BTN));
        touch_queue.push_back(mk_touch(1023, 0, N_BTN));
        touch_queue.push_back(mk_touch(cal_x_min, cal_y_min, N_BTN));
        touch_queue.push_back(mk_touch(cal_x_max, cal_y_max, N_BTN));
        for (int b = 0; b < grid_size; b++) begin
            touch_queue.push_back(mk_touch(
                raw_for(btn_x[b] + (btn_w[b] - tbht_pkg::BTN_TRIM) / 2,
                        cal_x_min, cal_x_max, SCR_W),
                raw_for(btn_y[b] + (btn_h[b] - tbht_pkg::BTN_TRIM) / 2,
                        cal_y_min, cal_y_max, SCR_H),
                N_BTN));
            touch_queue.push_back(mk_touch(
                raw_for(btn_x[b] + (btn_w[b] - tbht_pkg::BTN_TRIM) / 2,
                        cal_x_min, cal_x_max, SCR_W),
                raw_for(btn_y[b] + (btn_h[b] - tbht_pkg::BTN_TRIM) / 2,
                        cal_y_min, cal_y_max, SCR_H),
                b));
            touch_queue.push_back(mk_touch(
                raw_for(btn_x[b], cal_x_min, cal_x_max, SCR_W),
                raw_for(btn_y[b] + 5, cal_y_min, cal_y_max, SCR_H), 4));
            touch_queue.push_back(mk_touch(
                raw_for(btn_x[b] + btn_w[b] - tbht_pkg::BTN_TRIM + 1,
                        cal_x_min, cal_x_max, SCR_W),
                raw_for(btn_y[b] + 5, cal_y_min, cal_y_max, SCR_H), 4));
        end
        // Counts past the store: no extra buttons tested, miss returns the count
        touch_queue.push_back(mk_touch(raw_for(40, cal_x_min, cal_x_max, SCR_W),
                                       raw_for(224, cal_y_min, cal_y_max, SCR_H), 13));
        touch_queue.push_back(mk_touch(raw_for(280, cal_x_min, cal_x_max, SCR_W),
                                       raw_for(224, cal_y_min, cal_y_max, SCR_H), 14));
        drain();

        // Single column, full 12 rows, height below the minimum, grid runs off the top
        run_phase(1, 12, 0, 125, 907, 130, 935, 1'b0);
        // Two columns, rows over capacity, tallest buttons, full-range calibration, no idling
        run_phase(2, 15, 255, 0, 1023, 0, 1023, 1'b1);
        // Inverted x calibration: x maps to 0 and nothing hits
        run_phase(3, 4, 40, 1023, 0, 130, 935, 1'b0);
        // Zero columns counts as one; zero rows builds no buttons
        run_phase(0, 0, 19, 125, 907, 130, 935, 1'b0);
        // Columns above four; narrow windows drive both axes into saturation
        run_phase(7, 3, 60, 500, 510, 1000, 1023, 1'b0);
        // Equal y calibration limits are degenerate too
        run_phase(4, 1, 21, 125, 907, 512, 512, 1'b0);
        // One-count windows at opposite ends: extreme gain both ways
        run_phase(4, 3, 20, 0, 1, 1022, 1023, 1'b0);

        // Random settings, mostly with a usable calibration
        for (int p = 0; p < 5; p++) begin
            if ($urandom_range(0, 5) == 0)
                run_phase($urandom_range(0, 7), $urandom_range(0, 15), $urandom_range(0, 255),
                          $urandom_range(0, 1023), $urandom_range(0, 1023),
                          $urandom_range(0, 1023), $urandom_range(0, 1023), p == 2);
            else
                run_phase($urandom_range(0, 7), $urandom_range(0, 15),
                          $urandom_range(0, 1) ? $urandom_range(0, 40) : $urandom_range(0, 255),
                          $urandom_range(0, 400), $urandom_range(600, 1023),
                          $urandom_range(0, 400), $urandom_range(600, 1023), p == 2);
        end

        // Let any stray beat surface before judging
        repeat (60) @(posedge i_clk);
        if (expected_reports.size() != 0) begin
            $error("%0d expected reports never arrived", expected_reports.size());
            n_fail++;
        end
        $display("Run covered %0d register settings, %0d touches sent, %0d reports checked.",
                 n_settings, n_accepted, n_results);
        $display("Predicted %0d button hits; receiver held off for %0d long stretches.",
                 n_hits, n_chokes);
        if (n_fail == 0)
            $display("touch_button_hit_test_core_tb passed");
        else
            $display("touch_button_hit_test_core_tb failed");
        $finish;
    end

    // Watchdog: well beyond the slowest legal run
    initial begin
        #10_000_000;
        $display("Timeout with %0d reports still pending.", expected_reports.size());
        $display("touch_button_hit_test_core_tb failed");
        $finish;
    end

endmodule
